@@ src/bls_pkg.sv @@
// Shared constants and command codes for the line stepper.
`default_nettype none
package bls_pkg;

  localparam int COORD_BITS_DEF = 12;
  localparam int WIDTH_BITS = 8;
  localparam int RADIUS_BITS = 7;

  typedef enum logic {
    CMD_LOAD = 1'b0,
    CMD_NEXT = 1'b1
  } cmd_t;

endpackage
`default_nettype wire

@@ src/bls_setup.sv @@
// Line setup stage: case selection, endpoint ordering and initial error term.
`default_nettype none
module bls_setup #(
  parameter int COORD_BITS = bls_pkg::COORD_BITS_DEF,
  parameter int ERR_BITS   = COORD_BITS + 4
) (
  input  logic                              clk,
  input  logic                              en,
  input  logic                              cmd,
  input  logic signed [COORD_BITS-1:0]      start_x,
  input  logic signed [COORD_BITS-1:0]      start_y,
  input  logic signed [COORD_BITS-1:0]      end_x,
  input  logic signed [COORD_BITS-1:0]      end_y,
  input  logic [bls_pkg::WIDTH_BITS-1:0]    stroke_width,
  output logic                              ld_load,
  output logic                              ld_steep,
  output logic                              ld_minor_neg,
  output logic [COORD_BITS-1:0]             ld_major_delta,
  output logic [COORD_BITS-1:0]             ld_minor_delta,
  output logic signed [COORD_BITS-1:0]      ld_major_end,
  output logic signed [ERR_BITS-1:0]        ld_err,
  output logic signed [COORD_BITS-1:0]      ld_x,
  output logic signed [COORD_BITS-1:0]      ld_y,
  output logic [bls_pkg::RADIUS_BITS-1:0]   ld_radius
);
  import bls_pkg::*;

  logic signed [COORD_BITS:0]   dx;
  logic signed [COORD_BITS:0]   dy;
  logic [COORD_BITS-1:0]        adx;
  logic [COORD_BITS-1:0]        ady;
  logic                         steep;
  logic                         swap;
  logic signed [COORD_BITS-1:0] x0;
  logic signed [COORD_BITS-1:0] y0;
  logic signed [COORD_BITS-1:0] x1;
  logic signed [COORD_BITS-1:0] y1;
  logic signed [COORD_BITS:0]   maj_d;
  logic signed [COORD_BITS:0]   min_d;
  logic [COORD_BITS:0]          min_abs;
  logic [COORD_BITS-1:0]        major_delta;
  logic [COORD_BITS-1:0]        minor_delta;
  logic signed [ERR_BITS-1:0]   err;

  always_comb begin
    dx = (COORD_BITS+1)'(end_x) - (COORD_BITS+1)'(start_x);
    dy = (COORD_BITS+1)'(end_y) - (COORD_BITS+1)'(start_y);
    adx = dx[COORD_BITS] ? COORD_BITS'(-dx) : dx[COORD_BITS-1:0];
    ady = dy[COORD_BITS] ? COORD_BITS'(-dy) : dy[COORD_BITS-1:0];
    steep = !(ady < adx);
    swap = steep ? (start_y > end_y) : (start_x > end_x);
    x0 = swap ? end_x : start_x;
    y0 = swap ? end_y : start_y;
    x1 = swap ? start_x : end_x;
    y1 = swap ? start_y : end_y;
    if (steep) begin
      maj_d = (COORD_BITS+1)'(y1) - (COORD_BITS+1)'(y0);
      min_d = (COORD_BITS+1)'(x1) - (COORD_BITS+1)'(x0);
    end else begin
      maj_d = (COORD_BITS+1)'(x1) - (COORD_BITS+1)'(x0);
      min_d = (COORD_BITS+1)'(y1) - (COORD_BITS+1)'(y0);
    end
    major_delta = maj_d[COORD_BITS-1:0];
    min_abs = min_d[COORD_BITS] ? -min_d : min_d;
    minor_delta = min_abs[COORD_BITS-1:0];
    err = $signed(ERR_BITS'({minor_delta, 1'b0}) - ERR_BITS'(major_delta));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ld_load        <= (cmd == CMD_LOAD);
      ld_steep       <= steep;
      ld_minor_neg   <= min_d[COORD_BITS];
      ld_major_delta <= major_delta;
      ld_minor_delta <= minor_delta;
      ld_major_end   <= steep ? y1 : x1;
      ld_err         <= err;
      ld_x           <= x0;
      ld_y           <= y0;
      ld_radius      <= stroke_width[WIDTH_BITS-1:1];
    end
  end

endmodule
`default_nettype wire

@@ src/bls_step.sv @@
// Stepping stage: line state, end detection, error update and result register.
`default_nettype none
module bls_step #(
  parameter int COORD_BITS = bls_pkg::COORD_BITS_DEF,
  parameter int ERR_BITS   = COORD_BITS + 4
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              en,
  input  logic                              ld_load,
  input  logic                              ld_steep,
  input  logic                              ld_minor_neg,
  input  logic [COORD_BITS-1:0]             ld_major_delta,
  input  logic [COORD_BITS-1:0]             ld_minor_delta,
  input  logic signed [COORD_BITS-1:0]      ld_major_end,
  input  logic signed [ERR_BITS-1:0]        ld_err,
  input  logic signed [COORD_BITS-1:0]      ld_x,
  input  logic signed [COORD_BITS-1:0]      ld_y,
  input  logic [bls_pkg::RADIUS_BITS-1:0]   ld_radius,
  output logic signed [COORD_BITS-1:0]      point_x,
  output logic signed [COORD_BITS-1:0]      point_y,
  output logic [bls_pkg::RADIUS_BITS-1:0]   brush_radius,
  output logic                              final_point,
  output logic                              idle
);
  import bls_pkg::*;

  localparam logic signed [COORD_BITS-1:0] ONE = COORD_BITS'(1);

  logic signed [COORD_BITS-1:0] cur_x;
  logic signed [COORD_BITS-1:0] cur_y;
  logic signed [COORD_BITS-1:0] major_end;
  logic signed [ERR_BITS-1:0]   error_term;
  logic [COORD_BITS-1:0]        major_delta;
  logic [COORD_BITS-1:0]        minor_delta;
  logic                         minor_step_negative;
  logic                         steep_mode;
  logic                         line_active;
  logic [RADIUS_BITS-1:0]       radius_reg;

  logic signed [COORD_BITS-1:0] sx;
  logic signed [COORD_BITS-1:0] sy;
  logic signed [COORD_BITS-1:0] send;
  logic signed [ERR_BITS-1:0]   serr;
  logic [COORD_BITS-1:0]        smaj;
  logic [COORD_BITS-1:0]        smin;
  logic                         sneg;
  logic                         ssteep;
  logic [RADIUS_BITS-1:0]       srad;
  logic                         go;
  logic                         fin;
  logic signed [COORD_BITS-1:0] minor_cur;
  logic signed [COORD_BITS-1:0] minor_adj;
  logic signed [COORD_BITS-1:0] major_cur;
  logic signed [COORD_BITS-1:0] major_inc;
  logic signed [ERR_BITS-1:0]   err_next;
  logic signed [COORD_BITS-1:0] cur_x_next;
  logic signed [COORD_BITS-1:0] cur_y_next;

  always_comb begin
    sx     = ld_load ? ld_x : cur_x;
    sy     = ld_load ? ld_y : cur_y;
    send   = ld_load ? ld_major_end : major_end;
    serr   = ld_load ? ld_err : error_term;
    smaj   = ld_load ? ld_major_delta : major_delta;
    smin   = ld_load ? ld_minor_delta : minor_delta;
    sneg   = ld_load ? ld_minor_neg : minor_step_negative;
    ssteep = ld_load ? ld_steep : steep_mode;
    srad   = ld_load ? ld_radius : radius_reg;
    go     = ld_load || line_active;

    major_cur = ssteep ? sy : sx;
    minor_cur = ssteep ? sx : sy;
    fin = (major_cur >= send);
    major_inc = major_cur + ONE;
    if (serr > 0) begin
      minor_adj = sneg ? (minor_cur - ONE) : (minor_cur + ONE);
      err_next = $signed(serr + ERR_BITS'({smin, 1'b0}) - ERR_BITS'({smaj, 1'b0}));
    end else begin
      minor_adj = minor_cur;
      err_next = $signed(serr + ERR_BITS'({smin, 1'b0}));
    end
    cur_x_next = ssteep ? minor_adj : major_inc;
    cur_y_next = ssteep ? major_inc : minor_adj;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_x               <= '0;
      cur_y               <= '0;
      major_end           <= '0;
      error_term          <= '0;
      major_delta         <= '0;
      minor_delta         <= '0;
      minor_step_negative <= 1'b0;
      steep_mode          <= 1'b0;
      line_active         <= 1'b0;
      radius_reg          <= '0;
    end else if (en && go) begin
      major_end           <= send;
      major_delta         <= smaj;
      minor_delta         <= smin;
      minor_step_negative <= sneg;
      steep_mode          <= ssteep;
      radius_reg          <= srad;
      line_active         <= !fin;
      if (fin) begin
        cur_x      <= sx;
        cur_y      <= sy;
        error_term <= serr;
      end else begin
        cur_x      <= cur_x_next;
        cur_y      <= cur_y_next;
        error_term <= err_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (go) begin
        point_x      <= sx;
        point_y      <= sy;
        brush_radius <= srad;
        final_point  <= fin;
        idle         <= 1'b0;
      end else begin
        point_x      <= '0;
        point_y      <= '0;
        brush_radius <= '0;
        final_point  <= 1'b0;
        idle         <= 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

@@ src/bresenham_line_stepper.sv @@
// Top level of the Bresenham line stepper: input register, setup and stepping stages.
// Every command transfer yields exactly one point transfer. A load command orders the
// endpoints, picks the shallow or steep case and returns the first point; each next
// command returns the following point, with final_point set on the end point and idle
// set when no line is active. The block takes one command per cycle and returns one
// point per cycle unless point_stall holds the output; a command passes through three
// registers (input, setup, result) before its point is on the outputs. The line state
// update is a single add and compare loop closed through the line state registers.
`default_nettype none
module bresenham_line_stepper #(
  parameter int COORD_BITS = bls_pkg::COORD_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cmd_valid,
  output logic                              cmd_stall,
  input  logic                              cmd,
  input  logic signed [COORD_BITS-1:0]      start_x,
  input  logic signed [COORD_BITS-1:0]      start_y,
  input  logic signed [COORD_BITS-1:0]      end_x,
  input  logic signed [COORD_BITS-1:0]      end_y,
  input  logic [bls_pkg::WIDTH_BITS-1:0]    stroke_width,
  output logic                              point_valid,
  input  logic                              point_stall,
  output logic signed [COORD_BITS-1:0]      point_x,
  output logic signed [COORD_BITS-1:0]      point_y,
  output logic [bls_pkg::RADIUS_BITS-1:0]   brush_radius,
  output logic                              final_point,
  output logic                              idle
);
  import bls_pkg::*;

  localparam int ERR_BITS = COORD_BITS + 4;

  logic                         in_valid;
  logic                         in_cmd;
  logic signed [COORD_BITS-1:0] in_start_x;
  logic signed [COORD_BITS-1:0] in_start_y;
  logic signed [COORD_BITS-1:0] in_end_x;
  logic signed [COORD_BITS-1:0] in_end_y;
  logic [WIDTH_BITS-1:0]        in_width;
  logic                         setup_valid;

  logic                         out_free;
  logic                         setup_free;
  logic                         in_free;
  logic                         step_en;

  logic                         ld_load;
  logic                         ld_steep;
  logic                         ld_minor_neg;
  logic [COORD_BITS-1:0]        ld_major_delta;
  logic [COORD_BITS-1:0]        ld_minor_delta;
  logic signed [COORD_BITS-1:0] ld_major_end;
  logic signed [ERR_BITS-1:0]   ld_err;
  logic signed [COORD_BITS-1:0] ld_x;
  logic signed [COORD_BITS-1:0] ld_y;
  logic [RADIUS_BITS-1:0]       ld_radius;

  assign out_free   = !point_valid || !point_stall;
  assign setup_free = !setup_valid || out_free;
  assign in_free    = !in_valid || setup_free;
  assign step_en    = setup_valid && out_free;
  assign cmd_stall  = !in_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid    <= 1'b0;
      setup_valid <= 1'b0;
      point_valid <= 1'b0;
    end else begin
      if (in_free) begin
        in_valid <= cmd_valid;
      end
      if (setup_free) begin
        setup_valid <= in_valid;
      end
      if (out_free) begin
        point_valid <= setup_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_free && cmd_valid) begin
      in_cmd     <= cmd;
      in_start_x <= start_x;
      in_start_y <= start_y;
      in_end_x   <= end_x;
      in_end_y   <= end_y;
      in_width   <= stroke_width;
    end
  end

  bls_setup #(
    .COORD_BITS(COORD_BITS),
    .ERR_BITS  (ERR_BITS)
  ) u_setup (
    .clk           (clk),
    .en            (setup_free && in_valid),
    .cmd           (in_cmd),
    .start_x       (in_start_x),
    .start_y       (in_start_y),
    .end_x         (in_end_x),
    .end_y         (in_end_y),
    .stroke_width  (in_width),
    .ld_load       (ld_load),
    .ld_steep      (ld_steep),
    .ld_minor_neg  (ld_minor_neg),
    .ld_major_delta(ld_major_delta),
    .ld_minor_delta(ld_minor_delta),
    .ld_major_end  (ld_major_end),
    .ld_err        (ld_err),
    .ld_x          (ld_x),
    .ld_y          (ld_y),
    .ld_radius     (ld_radius)
  );

  bls_step #(
    .COORD_BITS(COORD_BITS),
    .ERR_BITS  (ERR_BITS)
  ) u_step (
    .clk           (clk),
    .rst           (rst),
    .en            (step_en),
    .ld_load       (ld_load),
    .ld_steep      (ld_steep),
    .ld_minor_neg  (ld_minor_neg),
    .ld_major_delta(ld_major_delta),
    .ld_minor_delta(ld_minor_delta),
    .ld_major_end  (ld_major_end),
    .ld_err        (ld_err),
    .ld_x          (ld_x),
    .ld_y          (ld_y),
    .ld_radius     (ld_radius),
    .point_x       (point_x),
    .point_y       (point_y),
    .brush_radius  (brush_radius),
    .final_point   (final_point),
    .idle          (idle)
  );

endmodule
`default_nettype wire
